FILE: rtl/rtb_pkg.sv
`timescale 1ns / 1ps

package rtb_pkg;

    // Width of a scaled gray sum and of the matching scaled threshold.
    // The largest value is 100 * 256 = 25600.
    localparam int CMP_W = 15;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GRAY_MODE = 4'd1;

    // Gray conversion methods.
    localparam logic [3:0] MODE_AVG       = 4'd0;
    localparam logic [3:0] MODE_LUMINANCE = 4'd1;
    localparam logic [3:0] MODE_LUMA      = 4'd2;
    localparam logic [3:0] MODE_DESAT     = 4'd3;
    localparam logic [3:0] MODE_MAX       = 4'd4;
    localparam logic [3:0] MODE_MIN       = 4'd5;
    localparam logic [3:0] MODE_RED       = 4'd6;
    localparam logic [3:0] MODE_GREEN     = 4'd7;
    localparam logic [3:0] MODE_BLUE      = 4'd8;

    localparam logic [3:0] GRAY_MODE_RESET = MODE_LUMINANCE;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_in_line;
    } t_pixel;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       end_of_line;
    } t_byte_out;

    // Threshold pre-multiplied by each divisor used in the gray methods.
    typedef struct packed {
        logic [CMP_W-1:0] x1;
        logic [CMP_W-1:0] x2;
        logic [CMP_W-1:0] x3;
        logic [CMP_W-1:0] x100;
    } t_thr_set;

endpackage

FILE: rtl/rtb_gray_cmp.sv
`timescale 1ns / 1ps

// Decides whether one pixel is white. floor(s / d) < t is the same as
// s < d * t, so the sum is compared with a pre-scaled threshold.
module rtb_gray_cmp (
    input  rtb_pkg::t_pixel   i_pix,
    input  logic [3:0]        i_mode,
    input  rtb_pkg::t_thr_set i_thr,
    output logic              o_white
);

    logic [rtb_pkg::CMP_W-1:0] r_w;
    logic [rtb_pkg::CMP_W-1:0] g_w;
    logic [rtb_pkg::CMP_W-1:0] b_w;
    logic [rtb_pkg::CMP_W-1:0] mx;
    logic [rtb_pkg::CMP_W-1:0] mn;
    logic [rtb_pkg::CMP_W-1:0] sum;
    logic [rtb_pkg::CMP_W-1:0] lim;

    assign r_w = rtb_pkg::CMP_W'(i_pix.red);
    assign g_w = rtb_pkg::CMP_W'(i_pix.green);
    assign b_w = rtb_pkg::CMP_W'(i_pix.blue);

    always_comb begin
        mx = (r_w > g_w) ? r_w : g_w;
        mx = (mx > b_w) ? mx : b_w;
        mn = (r_w < g_w) ? r_w : g_w;
        mn = (mn < b_w) ? mn : b_w;
    end

    always_comb begin
        case (i_mode)
            rtb_pkg::MODE_AVG: begin
                sum = r_w + g_w + b_w;
                lim = i_thr.x3;
            end
            rtb_pkg::MODE_LUMINANCE: begin
                sum = r_w * 15'd30 + g_w * 15'd59 + b_w * 15'd11;
                lim = i_thr.x100;
            end
            rtb_pkg::MODE_LUMA: begin
                sum = r_w * 15'd21 + g_w * 15'd72 + b_w * 15'd7;
                lim = i_thr.x100;
            end
            rtb_pkg::MODE_DESAT: begin
                sum = mx + mn;
                lim = i_thr.x2;
            end
            rtb_pkg::MODE_MAX: begin
                sum = mx;
                lim = i_thr.x1;
            end
            rtb_pkg::MODE_MIN: begin
                sum = mn;
                lim = i_thr.x1;
            end
            rtb_pkg::MODE_RED: begin
                sum = r_w;
                lim = i_thr.x1;
            end
            rtb_pkg::MODE_GREEN: begin
                sum = g_w;
                lim = i_thr.x1;
            end
            rtb_pkg::MODE_BLUE: begin
                sum = b_w;
                lim = i_thr.x1;
            end
            default: begin
                // Undefined methods give a gray level of zero.
                sum = '0;
                lim = i_thr.x1;
            end
        endcase
    end

    assign o_white = !(sum < lim);

endmodule

FILE: rtl/rgb_threshold_binarizer_unit.sv
`timescale 1ns / 1ps

// Path: an accepted item enters the input register; a pixel that completes a byte writes it to the output register.
// Throughput: one pixel item per cycle; a stalled output holds the pipeline only when the
// waiting pixel would complete a byte.
// Reset: synchronous, active low; clears the pipeline, the bit packer (start of a row),
// threshold to 0 and gray method to luminance.

module rgb_threshold_binarizer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rtb_pkg::t_pixel                 i_in,
    // Packed byte output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rtb_pkg::t_byte_out              o_out,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rtb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rtb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration. The threshold is kept already multiplied by every divisor
    // the gray methods use, so the pixel path needs no division at all.
    rtb_pkg::t_thr_set  r_thr;
    rtb_pkg::t_thr_set  n_thr;
    logic [3:0]         r_mode;
    logic [3:0]         n_mode;
    logic [rtb_pkg::CMP_W-1:0] cfg_thr;

    // Input register stage.
    logic               r_s1_valid;
    logic               n_s1_valid;
    rtb_pkg::t_pixel    r_s1_pix;

    // Bit packer state.
    logic [7:0]         r_acc;
    logic [7:0]         n_acc;
    logic [2:0]         r_pos;
    logic [2:0]         n_pos;

    // Output register.
    logic               r_out_valid;
    logic               n_out_valid;
    rtb_pkg::t_byte_out r_out;

    logic               white;
    logic               s1_emit;
    logic               s1_move;
    logic               out_free;
    logic               in_accept;
    logic [7:0]         acc_upd;

    // The configuration port never back-pressures.
    assign o_cfg_ready = 1'b1;

    // The threshold is the low nine bits of the data; any value above 256 already turns every
    // pixel black, so it is clipped to 256; this keeps the scaled copies within CMP_W bits.
    assign cfg_thr = (i_cfg_data[8:0] > 9'd256) ? rtb_pkg::CMP_W'(9'd256)
                                                 : rtb_pkg::CMP_W'(i_cfg_data[8:0]);

    always_comb begin
        n_thr  = r_thr;
        n_mode = r_mode;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rtb_pkg::CFG_IDX_THRESHOLD: begin
                    n_thr.x1   = cfg_thr;
                    n_thr.x2   = cfg_thr << 1;
                    n_thr.x3   = cfg_thr * 15'd3;
                    n_thr.x100 = cfg_thr * 15'd100;
                end
                rtb_pkg::CFG_IDX_GRAY_MODE: begin
                    n_mode = i_cfg_data[3:0];
                end
                default: begin
                    n_thr  = r_thr;
                    n_mode = r_mode;
                end
            endcase
        end
    end

    rtb_gray_cmp u_gray_cmp (
        .i_pix   (r_s1_pix),
        .i_mode  (r_mode),
        .i_thr   (r_thr),
        .o_white (white)
    );

    // A pixel leaves the input register when it either completes no byte or
    // the output register is free to take the byte it completes.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_emit    = r_s1_pix.last_in_line || (r_pos == 3'd7);
    assign s1_move    = r_s1_valid && (!s1_emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Bits are filled from bit 7 downwards; the bits not yet reached are
    // always zero, so a short byte at the end of a row is zero padded.
    assign acc_upd = r_acc | (white ? (8'h80 >> r_pos) : 8'h00);

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (s1_move) begin
            n_s1_valid = 1'b0;
            if (s1_emit) begin
                n_acc       = '0;
                n_pos       = '0;
                n_out_valid = 1'b1;
            end else begin
                n_acc = acc_upd;
                n_pos = r_pos + 3'd1;
            end
        end

        if (in_accept) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= '0;
            r_mode      <= rtb_pkg::GRAY_MODE_RESET;
            r_s1_valid  <= 1'b0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_thr       <= n_thr;
            r_mode      <= n_mode;
            r_s1_valid  <= n_s1_valid;
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix <= i_in;
        end
        if (s1_move && s1_emit) begin
            r_out.packed_byte <= acc_upd;
            r_out.end_of_line <= r_s1_pix.last_in_line;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // Bits at and below the current position have not been written yet.
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & (8'hFF >> r_pos)) == 8'h00)
        else $error("bit accumulator holds bits beyond the packing position");

    // After a byte leaves, packing restarts at the top bit of an empty byte.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && s1_emit) |=> (r_pos == 3'd0 && r_acc == 8'h00 && r_out_valid))
        else $error("packer did not restart after a byte was issued");

    // A byte that does not close a row must be a full one.
    a_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && s1_emit && !r_s1_pix.last_in_line) |-> (r_pos == 3'd7))
        else $error("partial byte issued without end of line");

    // A waiting byte is never dropped while the receiver stalls.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled output byte was lost");

    // Back-pressure only arises from a pixel held in the input register.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && s1_emit && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked pixel");
`endif

endmodule

FILE: sim/tb_rgb_threshold_binarizer_unit.sv
`timescale 1ns / 1ps

module tb_rgb_threshold_binarizer_unit;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 40;

    // Index outside the register map, written once to show it is ignored.
    localparam logic [rtb_pkg::CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 4'hF;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_kind;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    rtb_pkg::t_pixel                 i_in = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    rtb_pkg::t_byte_out              o_out;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rtb_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [rtb_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    rgb_threshold_binarizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Pixels waiting to be offered, and packed bytes the block still owes us.
    rtb_pkg::t_pixel    pixel_queue[$];
    rtb_pkg::t_byte_out byte_expect[$];

    // Predictor copy of the registers and of the bit packer.
    logic [8:0] thr_reg   = 9'd0;
    logic [3:0] mode_reg  = rtb_pkg::GRAY_MODE_RESET;
    logic [7:0] pack_bits = 8'd0;
    logic [2:0] pack_pos  = 3'd0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Long receiver hold-off, armed by bumping hold_trigger.
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic int gray_of(rtb_pkg::t_pixel p, logic [3:0] mode);
        int r, g, b, hi, lo;
        r  = p.red;
        g  = p.green;
        b  = p.blue;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        case (mode)
            rtb_pkg::MODE_AVG:       return (r + g + b) / 3;
            rtb_pkg::MODE_LUMINANCE: return (r * 30 + g * 59 + b * 11) / 100;
            rtb_pkg::MODE_LUMA:      return (r * 21 + g * 72 + b * 7) / 100;
            rtb_pkg::MODE_DESAT:     return (hi + lo) / 2;
            rtb_pkg::MODE_MAX:       return hi;
            rtb_pkg::MODE_MIN:       return lo;
            rtb_pkg::MODE_RED:       return r;
            rtb_pkg::MODE_GREEN:     return g;
            rtb_pkg::MODE_BLUE:      return b;
            default:                 return 0;
        endcase
    endfunction

    // Adds one pixel to the packer; a full byte or the end of a row yields a byte.
    task automatic pack_pixel(rtb_pkg::t_pixel p);
        logic [7:0]         mask;
        rtb_pkg::t_byte_out done;
        mask = 8'h80 >> pack_pos;
        if (gray_of(p, mode_reg) < int'(thr_reg))
            pack_bits &= ~mask;
        else
            pack_bits |= mask;
        if (p.last_in_line || pack_pos == 3'd7) begin
            done.packed_byte = pack_bits;
            done.end_of_line = p.last_in_line;
            byte_expect.push_back(done);
            pack_bits = 8'd0;
            pack_pos  = 3'd0;
        end else begin
            pack_pos = pack_pos + 3'd1;
        end
    endtask

    // Sender: a stalled item is held; otherwise the next one may be offered or a gap taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pack_pixel(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in       <= pixel_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each accepted byte against the oldest prediction.
    always @(posedge i_clk) begin
        rtb_pkg::t_byte_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (byte_expect.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing expected",
                                              o_out.packed_byte));
                end else begin
                    want = byte_expect.pop_front();
                    if (o_out.packed_byte !== want.packed_byte)
                        report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                                  o_out.packed_byte, want.packed_byte));
                    if (o_out.end_of_line !== want.end_of_line)
                        report_mismatch($sformatf("end_of_line %0b, expected %0b",
                                                  o_out.end_of_line, want.end_of_line));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic set_idling(t_idle_kind kind);
        send_idle_pct  = (kind == IDLE_SENDER)   ? 77 : (kind == IDLE_BOTH) ? 19 : 0;
        recv_stall_pct = (kind == IDLE_RECEIVER) ? 77 : (kind == IDLE_BOTH) ? 19 : 0;
    endtask

    // Writes happen only while the block is idle, so the predictor may follow at once.
    task automatic write_reg(logic [rtb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rtb_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rtb_pkg::CFG_IDX_THRESHOLD: thr_reg  = data[8:0];
            rtb_pkg::CFG_IDX_GRAY_MODE: mode_reg = data[3:0];
            default: ;
        endcase
    endtask

    // Waits until every item is taken and every byte has arrived, then lets the pipe settle.
    task automatic drain;
        @(posedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || byte_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_channel;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'd0;
        if (pick == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic rtb_pkg::t_pixel rand_pixel(logic last);
        rtb_pkg::t_pixel p;
        p.red          = rand_channel();
        p.green        = rand_channel();
        p.blue         = rand_channel();
        p.last_in_line = last;
        return p;
    endfunction

    task automatic queue_pixel(int r, int g, int b, logic last);
        rtb_pkg::t_pixel p;
        p.red          = 8'(r);
        p.green        = 8'(g);
        p.blue         = 8'(b);
        p.last_in_line = last;
        pixel_queue.push_back(p);
    endtask

    // Mostly whole rows of random width; the rest are loose pixels with a random row mark.
    task automatic queue_rows(int n_items, int loose_pct, int row_max);
        int made, len;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < loose_pct) begin
                pixel_queue.push_back(rand_pixel(1'($urandom_range(0, 1))));
                made++;
            end else begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, row_max);
                for (int k = 0; k < len; k++)
                    pixel_queue.push_back(rand_pixel(k == len - 1));
                made += len;
            end
        end
    endtask

    task automatic random_config;
        int thr, mode;
        case ($urandom_range(0, 9))
            0:       thr = 0;
            1:       thr = 256;
            2:       thr = $urandom_range(257, 511);
            default: thr = $urandom_range(1, 255);
        endcase
        mode = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15);
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, {7'($urandom_range(0, 127)), 9'(thr)});
        write_reg(rtb_pkg::CFG_IDX_GRAY_MODE, {12'($urandom_range(0, 4095)), 4'(mode)});
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        // At reset the threshold is zero, so even a black pixel comes out white.
        @(negedge i_clk);
        queue_pixel(0, 0, 0, 1'b1);
        drain();

        // Each gray method in turn, with a two-pixel row straddling mid-scale.
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'd128);
        for (int m = rtb_pkg::MODE_AVG; m <= rtb_pkg::MODE_BLUE; m++) begin
            write_reg(rtb_pkg::CFG_IDX_GRAY_MODE, 16'(m));
            @(negedge i_clk);
            queue_pixel(255, 130, 0, 1'b0);
            queue_pixel(10, 127, 255, 1'b1);
            drain();
        end

        // An undefined method gives gray level zero: white at threshold 0, black above.
        write_reg(rtb_pkg::CFG_IDX_GRAY_MODE, 16'd15);
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'd0);
        @(negedge i_clk);
        queue_pixel(255, 255, 255, 1'b1);
        drain();
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'd1);
        @(negedge i_clk);
        queue_pixel(255, 255, 255, 1'b1);
        drain();

        // Thresholds of 256 and beyond turn even full white black.
        write_reg(rtb_pkg::CFG_IDX_GRAY_MODE, 16'(rtb_pkg::MODE_MAX));
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'd256);
        @(negedge i_clk);
        queue_pixel(255, 255, 255, 1'b1);
        drain();
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'hFFFF);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        @(negedge i_clk);
        queue_pixel(255, 255, 255, 1'b1);
        drain();

        // Random rows under random settings, stepping through the idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            set_idling(t_idle_kind'(ph % 4));
            @(negedge i_clk);
            queue_rows(40, 15, 16);
            drain();
        end

        // Hold the receiver off while the sender keeps pushing, so the input backs up.
        write_reg(rtb_pkg::CFG_IDX_THRESHOLD, 16'd128);
        write_reg(rtb_pkg::CFG_IDX_GRAY_MODE, 16'(rtb_pkg::MODE_LUMINANCE));
        set_idling(IDLE_NONE);
        @(negedge i_clk);
        hold_trigger <= hold_trigger + 1;
        queue_rows(80, 0, 24);
        drain();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rtb_pkg.sv
rtl/rtb_gray_cmp.sv
rtl/rgb_threshold_binarizer_unit.sv
sim/tb_rgb_threshold_binarizer_unit.sv
